// ===== rtl/stt_pkg.sv =====
// Shared types, codes and character helpers for the source text tokenizer.
package stt_pkg;

	localparam int POSITION_BITS_DEF = 24;
	localparam int KW_DEPTH_DEF      = 7;

	// token kinds
	localparam logic [4:0] K_END = 5'd0, K_ERROR = 5'd1, K_IDENT = 5'd2, K_NUMBER = 5'd3,
		K_CHAR = 5'd4, K_VAR = 5'd5, K_WHILE = 5'd6, K_IF = 5'd7, K_ELSE = 5'd8,
		K_TRUE = 5'd9, K_FALSE = 5'd10, K_FN = 5'd11, K_RETURN = 5'd12, K_LPAREN = 5'd13,
		K_RPAREN = 5'd14, K_SEMI = 5'd15, K_PLUS = 5'd16, K_MINUS = 5'd17, K_STAR = 5'd18,
		K_SLASH = 5'd19, K_COMMA = 5'd20, K_BANG = 5'd21, K_BANG_EQ = 5'd22, K_EQ = 5'd23,
		K_EQ_EQ = 5'd24, K_LESS = 5'd25, K_LESS_EQ = 5'd26, K_GREATER = 5'd27,
		K_GREATER_EQ = 5'd28;

	// error codes
	localparam logic [1:0] E_NONE = 2'd0, E_UNEXPECTED = 2'd1, E_UNSUPPORTED = 2'd2,
		E_UNTERMINATED = 2'd3;

	// value types
	localparam logic [2:0] T_UNKNOWN = 3'd0, T_INT = 3'd1, T_CHAR = 3'd2, T_BYTE = 3'd3,
		T_BOOL = 3'd4;

	typedef enum logic [3:0] {
		M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUMBER, M_OP2, M_QUOTE1, M_QUOTE2,
		M_PROBE_WS, M_PROBE_SLASH, M_PROBE_COMMENT, M_PROBE_MATCH
	} mode_t;

	typedef enum logic [2:0] {LEN_PEND, LEN_ZERO, LEN_ONE, LEN_TWO, LEN_THREE} len_sel_t;

	typedef struct packed {
		logic       consume;
		logic       adv;
		logic       line_inc;
		logic       start_tok;
		logic       len_inc;
		logic       pref_wr;
		logic       pline_set;
		logic       op_wr;
		logic [7:0] op_val;
		logic       hold_wr;
		logic [1:0] hold_idx;
		logic       hc_set;
		logic [2:0] hc_val;
		logic       replay;
		logic [2:0] replay_n;
		logic       clear;
		logic       emit;
		logic [4:0] kind;
		logic [2:0] vtype;
		logic       start_pos;
		len_sel_t   len_sel;
		logic       line_pend;
		logic [1:0] err;
	} cmd_t;

	typedef struct packed {
		logic       step;
		logic [7:0] head;
		logic       head_end;
		logic [4:0] kw_kind;
		logic [7:0] pend_op;
		logic [7:0] hold0;
		logic [2:0] hold_cnt;
	} status_t;

	function automatic logic is_letter(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_blank(logic [7:0] b);
		return b == " " || b == 8'h0d || b == 8'h09;
	endfunction

	function automatic logic [4:0] single_kind(logic [7:0] b);
		logic [4:0] k;
		case (b)
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			";":     k = K_SEMI;
			"+":     k = K_PLUS;
			"-":     k = K_MINUS;
			"*":     k = K_STAR;
			",":     k = K_COMMA;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] op_kind(logic [7:0] op, logic twin);
		logic [4:0] k;
		case (op)
			"!":     k = twin ? K_BANG_EQ : K_BANG;
			"=":     k = twin ? K_EQ_EQ : K_EQ;
			"<":     k = twin ? K_LESS_EQ : K_LESS;
			default: k = twin ? K_GREATER_EQ : K_GREATER;
		endcase
		return k;
	endfunction

	// letter i of a type word
	function automatic logic [7:0] type_chr(logic [2:0] t, logic [2:0] i);
		logic [31:0] w;
		case (t)
			T_INT:   w = {"int", 8'h00};
			T_CHAR:  w = "char";
			T_BYTE:  w = "byte";
			T_BOOL:  w = "bool";
			default: w = 32'h0;
		endcase
		case (i)
			3'd0:    return w[31:24];
			3'd1:    return w[23:16];
			3'd2:    return w[15:8];
			3'd3:    return w[7:0];
			default: return 8'h00;
		endcase
	endfunction

endpackage

// ===== rtl/stt_ctrl.sv =====
// Scanner state machine: decides one scan step per cycle from the head byte, unless the datapath stalls it.
module stt_ctrl
	import stt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t st,
	output cmd_t    cmd
);

	mode_t mode_q, mode_d;
	logic [7:0] b;
	logic e, ok;
	logic [2:0] t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= M_IDLE;
		else if (st.step) mode_q <= mode_d;
	end

	always_comb begin
		b = st.head;
		e = st.head_end;
		cmd = '0;
		cmd.len_sel = LEN_PEND;
		mode_d = mode_q;
		t = st.pend_op[2:0];
		ok = 1'b0;
		unique case (mode_q)
			M_IDLE: begin
				cmd.consume = 1'b1;
				if (e) begin
					cmd.emit = 1'b1; cmd.kind = K_END; cmd.start_pos = 1'b1;
					cmd.len_sel = LEN_ZERO; cmd.clear = 1'b1;
				end else if (is_blank(b)) begin
					cmd.adv = 1'b1;
				end else if (b == 8'h0a) begin
					cmd.adv = 1'b1; cmd.line_inc = 1'b1;
				end else begin
					cmd.adv = 1'b1; cmd.start_tok = 1'b1;
					if (is_letter(b) || b == "_") begin
						cmd.pref_wr = 1'b1; mode_d = M_IDENT;
					end else if (is_digit(b)) mode_d = M_NUMBER;
					else if (b == "/") mode_d = M_SLASH;
					else if (b == "!" || b == "=" || b == "<" || b == ">") begin
						cmd.op_wr = 1'b1; cmd.op_val = b; mode_d = M_OP2;
					end else if (b == "'") mode_d = M_QUOTE1;
					else begin
						cmd.emit = 1'b1; cmd.kind = single_kind(b); cmd.start_pos = 1'b1;
						cmd.len_sel = LEN_ONE;
						cmd.err = (single_kind(b) == K_ERROR) ? E_UNEXPECTED : E_NONE;
					end
				end
			end
			M_SLASH: begin
				mode_d = M_IDLE;
				if (!e && b == "/") begin
					cmd.adv = 1'b1; cmd.consume = 1'b1; mode_d = M_COMMENT;
				end else begin
					cmd.emit = 1'b1; cmd.kind = K_SLASH; cmd.len_sel = LEN_ONE;
				end
			end
			M_COMMENT: begin
				if (e) mode_d = M_IDLE;
				else begin
					cmd.adv = 1'b1; cmd.consume = 1'b1;
					if (b == 8'h0a) begin
						cmd.line_inc = 1'b1; mode_d = M_IDLE;
					end
				end
			end
			M_IDENT: begin
				if (!e && (is_letter(b) || is_digit(b) || b == "_")) begin
					cmd.pref_wr = 1'b1; cmd.len_inc = 1'b1; cmd.adv = 1'b1; cmd.consume = 1'b1;
				end else if (st.kw_kind == K_VAR) begin
					cmd.pline_set = 1'b1; mode_d = M_PROBE_WS;
				end else begin
					cmd.emit = 1'b1; cmd.kind = st.kw_kind; mode_d = M_IDLE;
				end
			end
			M_NUMBER: begin
				if (!e && is_digit(b)) begin
					cmd.len_inc = 1'b1; cmd.adv = 1'b1; cmd.consume = 1'b1;
				end else begin
					cmd.emit = 1'b1; cmd.kind = K_NUMBER; mode_d = M_IDLE;
				end
			end
			M_OP2: begin
				mode_d = M_IDLE;
				cmd.emit = 1'b1;
				if (!e && b == "=") begin
					cmd.adv = 1'b1; cmd.consume = 1'b1;
					cmd.kind = op_kind(st.pend_op, 1'b1); cmd.len_sel = LEN_TWO;
				end else begin
					cmd.kind = op_kind(st.pend_op, 1'b0); cmd.len_sel = LEN_ONE;
				end
			end
			M_QUOTE1: begin
				if (e) begin
					cmd.emit = 1'b1; cmd.kind = K_ERROR; cmd.len_sel = LEN_ONE;
					cmd.err = E_UNTERMINATED; mode_d = M_IDLE;
				end else begin
					cmd.hold_wr = 1'b1; cmd.adv = 1'b1; cmd.consume = 1'b1; mode_d = M_QUOTE2;
				end
			end
			M_QUOTE2: begin
				mode_d = M_IDLE;
				cmd.emit = 1'b1;
				if (!e && is_letter(st.hold0) && b == "'") begin
					cmd.adv = 1'b1; cmd.consume = 1'b1; cmd.kind = K_CHAR;
					cmd.len_sel = LEN_THREE;
				end else begin
					cmd.kind = K_ERROR; cmd.len_sel = LEN_ONE;
					cmd.err = (!e && b == "'") ? E_UNSUPPORTED : E_UNTERMINATED;
					cmd.replay = 1'b1; cmd.replay_n = 3'd1;
				end
			end
			M_PROBE_WS: begin
				if (!e && is_blank(b)) begin
					cmd.adv = 1'b1; cmd.consume = 1'b1;
				end else if (!e && b == 8'h0a) begin
					cmd.adv = 1'b1; cmd.consume = 1'b1; cmd.line_inc = 1'b1;
				end else if (!e && (b == "/" || b == "i" || b == "c" || b == "b")) begin
					cmd.hold_wr = 1'b1; cmd.hc_set = 1'b1; cmd.hc_val = 3'd1;
					cmd.adv = 1'b1; cmd.consume = 1'b1;
					if (b == "/") mode_d = M_PROBE_SLASH;
					else begin
						cmd.op_wr = 1'b1;
						cmd.op_val = (b == "i") ? 8'(T_INT) : (b == "c") ? 8'(T_CHAR) : 8'd0;
						mode_d = M_PROBE_MATCH;
					end
				end else begin
					cmd.emit = 1'b1; cmd.kind = K_VAR; cmd.line_pend = 1'b1; mode_d = M_IDLE;
				end
			end
			M_PROBE_SLASH: begin
				if (!e && b == "/") begin
					cmd.adv = 1'b1; cmd.consume = 1'b1; cmd.hc_set = 1'b1; cmd.hc_val = 3'd0;
					mode_d = M_PROBE_COMMENT;
				end else begin
					cmd.emit = 1'b1; cmd.kind = K_VAR; cmd.line_pend = 1'b1; mode_d = M_IDLE;
					cmd.replay = 1'b1; cmd.replay_n = st.hold_cnt;
				end
			end
			M_PROBE_COMMENT: begin
				if (e) begin
					cmd.emit = 1'b1; cmd.kind = K_VAR; cmd.line_pend = 1'b1; mode_d = M_IDLE;
				end else begin
					cmd.adv = 1'b1; cmd.consume = 1'b1;
					if (b == 8'h0a) begin
						cmd.line_inc = 1'b1; mode_d = M_PROBE_WS;
					end
				end
			end
			M_PROBE_MATCH: begin
				// a leading b is settled by its second letter
				if (!e && t == T_UNKNOWN && st.hold_cnt == 3'd1) begin
					if (b == "y") t = T_BYTE;
					else if (b == "o") t = T_BOOL;
				end
				ok = !e && t >= T_INT && t <= T_BOOL && st.hold_cnt < 3'd4 &&
					b == type_chr(t, st.hold_cnt);
				mode_d = M_IDLE;
				cmd.emit = 1'b1; cmd.kind = K_VAR; cmd.line_pend = 1'b1;
				if (ok) begin
					cmd.op_wr = 1'b1; cmd.op_val = 8'(t);
					cmd.hold_wr = 1'b1; cmd.hold_idx = st.hold_cnt[1:0];
					cmd.hc_set = 1'b1; cmd.hc_val = st.hold_cnt + 3'd1;
					cmd.adv = 1'b1; cmd.consume = 1'b1;
					if ((t == T_INT && st.hold_cnt == 3'd2) || (t != T_INT && st.hold_cnt == 3'd3))
						cmd.vtype = t;
					else begin
						cmd.emit = 1'b0; mode_d = M_PROBE_MATCH;
					end
				end else begin
					cmd.replay = 1'b1; cmd.replay_n = st.hold_cnt;
				end
			end
			default: mode_d = M_IDLE;
		endcase
		if (!st.step) cmd = '0;
	end

endmodule

// ===== rtl/stt_dp.sv =====
// Scanner datapath: counters, held bytes, keyword prefix, token buffer and output word.
module stt_dp
	import stt_pkg::*;
#(
	parameter int POSITION_BITS        = POSITION_BITS_DEF,
	parameter int KEYWORD_PREFIX_DEPTH = KW_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               text_byte,
	input  logic                     end_of_text,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [4:0]               token_kind,
	output logic [2:0]               value_type,
	output logic [POSITION_BITS-1:0] token_start,
	output logic [15:0]              token_length,
	output logic [15:0]              line_number,
	output logic [1:0]               error_code,
	output logic                     last_of_run,
	input  cmd_t                     cmd,
	output status_t                  st
);

	logic [7:0]               item_q;
	logic                     item_end_q, item_valid_q, flush_q;
	logic [POSITION_BITS-1:0] pos_q, pstart_q;
	logic [15:0]              line_q, pline_q, plen_q;
	logic [7:0]               op_q;
	logic [7:0]               hold_q [4];
	logic [2:0]               hc_q, rp_cnt_q;
	logic [1:0]               rp_idx_q;
	logic [7:0]               pfx_q [KEYWORD_PREFIX_DEPTH];

	logic                     tok_valid_q;
	logic [4:0]               tok_kind_q;
	logic [2:0]               tok_vtype_q;
	logic [POSITION_BITS-1:0] tok_start_q;
	logic [15:0]              tok_len_q, tok_line_q;
	logic [1:0]               tok_err_q;

	logic       room, from_rp, push_old, end_step;
	logic [7:0] head;
	logic [15:0] new_len;
	logic [4:0] kw;

	assign room     = !out_valid || out_ready;
	assign from_rp  = rp_cnt_q != 3'd0;
	assign head     = from_rp ? hold_q[rp_idx_q] : item_q;
	assign in_ready = !item_valid_q && !flush_q;
	assign push_old = cmd.emit && tok_valid_q;
	assign end_step = cmd.consume && !from_rp && (cmd.emit || tok_valid_q);

	always_comb begin
		kw = K_IDENT;
		if (plen_q == 16'd3 && pfx_q[0] == "v" && pfx_q[1] == "a" && pfx_q[2] == "r") kw = K_VAR;
		if (plen_q == 16'd5 && pfx_q[0] == "w" && pfx_q[1] == "h" && pfx_q[2] == "i" &&
			pfx_q[3] == "l" && pfx_q[4] == "e") kw = K_WHILE;
		if (plen_q == 16'd2 && pfx_q[0] == "i" && pfx_q[1] == "f") kw = K_IF;
		if (plen_q == 16'd4 && pfx_q[0] == "e" && pfx_q[1] == "l" && pfx_q[2] == "s" &&
			pfx_q[3] == "e") kw = K_ELSE;
		if (plen_q == 16'd4 && pfx_q[0] == "t" && pfx_q[1] == "r" && pfx_q[2] == "u" &&
			pfx_q[3] == "e") kw = K_TRUE;
		if (plen_q == 16'd5 && pfx_q[0] == "f" && pfx_q[1] == "a" && pfx_q[2] == "l" &&
			pfx_q[3] == "s" && pfx_q[4] == "e") kw = K_FALSE;
		if (plen_q == 16'd2 && pfx_q[0] == "f" && pfx_q[1] == "n") kw = K_FN;
		if (plen_q == 16'd6 && pfx_q[0] == "r" && pfx_q[1] == "e" && pfx_q[2] == "t" &&
			pfx_q[3] == "u" && pfx_q[4] == "r" && pfx_q[5] == "n") kw = K_RETURN;
	end

	always_comb begin
		st = '0;
		st.step     = (from_rp || item_valid_q) && room && !flush_q;
		st.head     = head;
		st.head_end = !from_rp && item_end_q;
		st.kw_kind  = kw;
		st.pend_op  = op_q;
		st.hold0    = hold_q[0];
		st.hold_cnt = hc_q;
	end

	always_comb begin
		case (cmd.len_sel)
			LEN_ZERO:  new_len = 16'd0;
			LEN_ONE:   new_len = 16'd1;
			LEN_TWO:   new_len = 16'd2;
			LEN_THREE: new_len = 16'd3;
			default:   new_len = plen_q;
		endcase
	end

	// input word and replay queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
			flush_q      <= 1'b0;
			rp_cnt_q     <= 3'd0;
			rp_idx_q     <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				item_valid_q <= 1'b1;
				item_q       <= text_byte;
				item_end_q   <= end_of_text;
			end
			if (cmd.consume) begin
				if (from_rp) begin
					rp_cnt_q <= rp_cnt_q - 3'd1;
					rp_idx_q <= rp_idx_q + 2'd1;
				end else begin
					item_valid_q <= 1'b0;
				end
			end
			if (cmd.replay) begin
				rp_cnt_q <= cmd.replay_n;
				rp_idx_q <= 2'd0;
			end
			if (end_step) flush_q <= 1'b1;
			else if (flush_q && room) flush_q <= 1'b0;
		end
	end

	// scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			line_q   <= 16'd1;
			pstart_q <= '0;
			plen_q   <= 16'd0;
			op_q     <= 8'd0;
			hc_q     <= 3'd0;
			pline_q  <= 16'd1;
		end else if (cmd.clear) begin
			pos_q    <= '0;
			line_q   <= 16'd1;
			pstart_q <= '0;
			plen_q   <= 16'd0;
			op_q     <= 8'd0;
			hc_q     <= 3'd0;
			pline_q  <= 16'd1;
		end else begin
			if (cmd.adv) pos_q <= pos_q + 1'b1;
			else if (cmd.replay) pos_q <= pos_q - POSITION_BITS'(cmd.replay_n);
			if (cmd.line_inc && line_q != 16'hffff) line_q <= line_q + 16'd1;
			if (cmd.start_tok) begin
				pstart_q <= pos_q;
				plen_q   <= 16'd1;
			end else if (cmd.len_inc && plen_q != 16'hffff) plen_q <= plen_q + 16'd1;
			if (cmd.op_wr) op_q <= cmd.op_val;
			if (cmd.hc_set) hc_q <= cmd.hc_val;
			if (cmd.pline_set) pline_q <= line_q;
		end
	end

	// held bytes and keyword prefix: contents undefined until written
	always_ff @(posedge clk) begin
		if (cmd.hold_wr) hold_q[cmd.hold_idx] <= head;
		if (cmd.pref_wr) begin
			if (cmd.start_tok) pfx_q[0] <= head;
			else begin
				for (int i = 0; i < KEYWORD_PREFIX_DEPTH; i++)
					if (plen_q == 16'(i)) pfx_q[i] <= head;
			end
		end
	end

	// one token is held back so the final word of a byte can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (push_old || (flush_q && room)) begin
				out_valid    <= 1'b1;
				token_kind   <= tok_kind_q;
				value_type   <= tok_vtype_q;
				token_start  <= tok_start_q;
				token_length <= tok_len_q;
				line_number  <= tok_line_q;
				error_code   <= tok_err_q;
				last_of_run  <= flush_q;
			end else if (out_valid && out_ready) out_valid <= 1'b0;
			if (flush_q && room) tok_valid_q <= 1'b0;
			if (cmd.emit) begin
				tok_valid_q <= 1'b1;
				tok_kind_q  <= cmd.kind;
				tok_vtype_q <= cmd.vtype;
				tok_start_q <= cmd.start_pos ? pos_q : pstart_q;
				tok_len_q   <= new_len;
				tok_line_q  <= cmd.line_pend ? pline_q : line_q;
				tok_err_q   <= cmd.err;
			end
		end
	end

endmodule

// ===== rtl/source_text_tokenizer_top.sv =====
// Top level of the source text tokenizer.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | text_byte, end_of_text
//  out     | output    | out_valid/out_ready | token_kind .. last_of_run
//
// A byte is taken into the input register, then scanned in steps: one that uses it up,
// one more for each token it closes (the byte is then looked at again), and one per
// held byte replayed after a failed type probe or char literal; a byte that produced
// tokens then has its last word marked before the next byte is taken. Every step
// stalls while the output register holds a word not taken. Reset and the end word
// clear all counters.
module source_text_tokenizer_top
	import stt_pkg::*;
#(
	parameter int POSITION_BITS        = POSITION_BITS_DEF,
	parameter int KEYWORD_PREFIX_DEPTH = KW_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               text_byte,
	input  logic                     end_of_text,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [4:0]               token_kind,
	output logic [2:0]               value_type,
	output logic [POSITION_BITS-1:0] token_start,
	output logic [15:0]              token_length,
	output logic [15:0]              line_number,
	output logic [1:0]               error_code,
	output logic                     last_of_run
);

	cmd_t    cmd;
	status_t st;

	stt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	stt_dp #(
		.POSITION_BITS        (POSITION_BITS),
		.KEYWORD_PREFIX_DEPTH (KEYWORD_PREFIX_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.value_type   (value_type),
		.token_start  (token_start),
		.token_length (token_length),
		.line_number  (line_number),
		.error_code   (error_code),
		.last_of_run  (last_of_run),
		.cmd          (cmd),
		.st           (st)
	);

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_END |-> last_of_run && token_length == 16'd0)
		else $error("end word not last of its byte");

	a_type_on_var: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_type != T_UNKNOWN |-> token_kind == K_VAR)
		else $error("type attached to a non-var word");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != E_NONE |-> token_kind == K_ERROR && token_length == 16'd1)
		else $error("error code on a malformed word");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second byte taken before the first was scanned");

endmodule

// ===== sim/source_text_tokenizer_top_tb.sv =====
// Self-checking testbench for the source text tokenizer top level.
`timescale 1ns / 100ps

module source_text_tokenizer_top_tb;
	import stt_pkg::*;

	typedef struct packed {
		logic [4:0]  kind;
		logic [2:0]  vtype;
		logic [23:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [1:0]  err;
		logic        last;
	} token_t;

	localparam int END_ITEM = 256;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  text_byte = 8'h00;
	logic        end_of_text = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  token_kind;
	logic [2:0]  value_type;
	logic [23:0] token_start;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic [1:0]  error_code;
	logic        last_of_run;

	source_text_tokenizer_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scanner mirror
	mode_t       scan_mode;
	logic [23:0] scan_pos;
	int          scan_line;
	logic [23:0] tok_start;
	int          tok_len;
	logic [7:0]  prefix [7];
	logic [7:0]  held_op;
	logic [7:0]  held [4];
	int          held_cnt;
	int          var_line;
	int          rescan_q [$];
	token_t      step_tokens [$];
	token_t      expected_tokens [$];

	int fail_count = 0;
	int bytes_sent = 0;
	int texts_sent = 0;
	int tokens_seen = 0;
	int burst_left = 0;

	function automatic void scanner_clear();
		scan_mode = M_IDLE;
		scan_pos  = '0;
		scan_line = 1;
		tok_start = '0;
		tok_len   = 0;
		held_op   = '0;
		held_cnt  = 0;
		var_line  = 1;
		foreach (prefix[i]) prefix[i] = '0;
		foreach (held[i]) held[i] = '0;
	endfunction

	function automatic bit letter(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit blank(logic [7:0] b);
		return b == " " || b == 8'h0d || b == 8'h09;
	endfunction

	function automatic void push_token(logic [4:0] k, logic [2:0] vt, logic [23:0] s, int len,
		int ln, logic [1:0] e);
		token_t t;
		if (step_tokens.size() >= 6) return;
		t.kind  = k;
		t.vtype = vt;
		t.start = s;
		t.len   = len > 65535 ? 16'hffff : len[15:0];
		t.line  = ln[15:0];
		t.err   = e;
		t.last  = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void bump_line();
		if (scan_line < 65535) scan_line++;
	endfunction

	function automatic void put_back(int n);
		if (n > 4) n = 4;
		if (rescan_q.size() + n > 8) return;
		for (int i = n - 1; i >= 0; i--) rescan_q.push_front(held[i]);
		scan_pos = scan_pos - n;
	endfunction

	function automatic bit word_is(string w);
		if (tok_len != w.len()) return 0;
		for (int i = 0; i < w.len(); i++)
			if (prefix[i] != w[i]) return 0;
		return 1;
	endfunction

	function automatic logic [4:0] word_kind();
		if (tok_len < 2 || tok_len > 6) return K_IDENT;
		if (word_is("var")) return K_VAR;
		if (word_is("while")) return K_WHILE;
		if (word_is("if")) return K_IF;
		if (word_is("else")) return K_ELSE;
		if (word_is("true")) return K_TRUE;
		if (word_is("false")) return K_FALSE;
		if (word_is("fn")) return K_FN;
		if (word_is("return")) return K_RETURN;
		return K_IDENT;
	endfunction

	function automatic logic [7:0] type_letter(int t, int i);
		string w;
		case (t)
			1: w = "int";
			2: w = "char";
			3: w = "byte";
			4: w = "bool";
			default: w = "";
		endcase
		return i < w.len() ? w[i] : 8'h00;
	endfunction

	function automatic logic [4:0] pair_kind(logic [7:0] op, bit twin);
		case (op)
			"!":     return twin ? K_BANG_EQ : K_BANG;
			"=":     return twin ? K_EQ_EQ : K_EQ;
			"<":     return twin ? K_LESS_EQ : K_LESS;
			default: return twin ? K_GREATER_EQ : K_GREATER;
		endcase
	endfunction

	function automatic logic [4:0] lone_kind(logic [7:0] b);
		case (b)
			"(":     return K_LPAREN;
			")":     return K_RPAREN;
			";":     return K_SEMI;
			"+":     return K_PLUS;
			"-":     return K_MINUS;
			"*":     return K_STAR;
			",":     return K_COMMA;
			default: return K_ERROR;
		endcase
	endfunction

	// one scan step; returns 1 when the item is used up
	function automatic bit scan_one(int c);
		bit          fin;
		logic [7:0]  b;
		logic [4:0]  k;
		int          t;
		fin = (c == END_ITEM);
		b   = c[7:0];
		case (scan_mode)
			M_IDLE: begin
				if (fin) begin
					push_token(K_END, T_UNKNOWN, scan_pos, 0, scan_line, E_NONE);
					scanner_clear();
					return 1;
				end
				if (blank(b)) begin
					scan_pos++;
					return 1;
				end
				if (b == 8'h0a) begin
					bump_line();
					scan_pos++;
					return 1;
				end
				tok_start = scan_pos;
				tok_len   = 1;
				scan_pos++;
				if (letter(b) || b == "_") begin
					prefix[0] = b;
					scan_mode = M_IDENT;
				end else if (digit(b)) scan_mode = M_NUMBER;
				else if (b == "/") scan_mode = M_SLASH;
				else if (b == "!" || b == "=" || b == "<" || b == ">") begin
					held_op   = b;
					scan_mode = M_OP2;
				end else if (b == "'") scan_mode = M_QUOTE1;
				else begin
					k = lone_kind(b);
					push_token(k, T_UNKNOWN, tok_start, 1, scan_line,
						k == K_ERROR ? E_UNEXPECTED : E_NONE);
				end
				return 1;
			end
			M_SLASH: begin
				if (!fin && b == "/") begin
					scan_pos++;
					scan_mode = M_COMMENT;
					return 1;
				end
				push_token(K_SLASH, T_UNKNOWN, tok_start, 1, scan_line, E_NONE);
				scan_mode = M_IDLE;
				return 0;
			end
			M_COMMENT: begin
				if (fin) begin
					scan_mode = M_IDLE;
					return 0;
				end
				if (b == 8'h0a) begin
					bump_line();
					scan_mode = M_IDLE;
				end
				scan_pos++;
				return 1;
			end
			M_IDENT: begin
				if (!fin && (letter(b) || digit(b) || b == "_")) begin
					if (tok_len < 7) prefix[tok_len] = b;
					if (tok_len < 65535) tok_len++;
					scan_pos++;
					return 1;
				end
				k = word_kind();
				if (k == K_VAR) begin
					var_line  = scan_line;
					scan_mode = M_PROBE_WS;
					return 0;
				end
				push_token(k, T_UNKNOWN, tok_start, tok_len, scan_line, E_NONE);
				scan_mode = M_IDLE;
				return 0;
			end
			M_NUMBER: begin
				if (!fin && digit(b)) begin
					if (tok_len < 65535) tok_len++;
					scan_pos++;
					return 1;
				end
				push_token(K_NUMBER, T_UNKNOWN, tok_start, tok_len, scan_line, E_NONE);
				scan_mode = M_IDLE;
				return 0;
			end
			M_OP2: begin
				scan_mode = M_IDLE;
				if (!fin && b == "=") begin
					scan_pos++;
					push_token(pair_kind(held_op, 1), T_UNKNOWN, tok_start, 2, scan_line, E_NONE);
					return 1;
				end
				push_token(pair_kind(held_op, 0), T_UNKNOWN, tok_start, 1, scan_line, E_NONE);
				return 0;
			end
			M_QUOTE1: begin
				if (fin) begin
					push_token(K_ERROR, T_UNKNOWN, tok_start, 1, scan_line, E_UNTERMINATED);
					scan_mode = M_IDLE;
					return 0;
				end
				held[0] = b;
				scan_pos++;
				scan_mode = M_QUOTE2;
				return 1;
			end
			M_QUOTE2: begin
				scan_mode = M_IDLE;
				if (!fin && letter(held[0]) && b == "'") begin
					scan_pos++;
					push_token(K_CHAR, T_UNKNOWN, tok_start, 3, scan_line, E_NONE);
					return 1;
				end
				push_token(K_ERROR, T_UNKNOWN, tok_start, 1, scan_line,
					(!fin && b == "'") ? E_UNSUPPORTED : E_UNTERMINATED);
				put_back(1);
				return 0;
			end
			M_PROBE_WS: begin
				if (!fin) begin
					if (blank(b)) begin
						scan_pos++;
						return 1;
					end
					if (b == 8'h0a) begin
						bump_line();
						scan_pos++;
						return 1;
					end
					if (b == "/" || b == "i" || b == "c" || b == "b") begin
						held[0]  = b;
						held_cnt = 1;
						scan_pos++;
						if (b == "/") begin
							scan_mode = M_PROBE_SLASH;
							return 1;
						end
						held_op   = (b == "i") ? 8'd1 : (b == "c") ? 8'd2 : 8'd0;
						scan_mode = M_PROBE_MATCH;
						return 1;
					end
				end
				push_token(K_VAR, T_UNKNOWN, tok_start, tok_len, var_line, E_NONE);
				scan_mode = M_IDLE;
				return 0;
			end
			M_PROBE_SLASH: begin
				if (!fin && b == "/") begin
					scan_pos++;
					held_cnt  = 0;
					scan_mode = M_PROBE_COMMENT;
					return 1;
				end
				push_token(K_VAR, T_UNKNOWN, tok_start, tok_len, var_line, E_NONE);
				scan_mode = M_IDLE;
				put_back(held_cnt);
				return 0;
			end
			M_PROBE_COMMENT: begin
				if (fin) begin
					push_token(K_VAR, T_UNKNOWN, tok_start, tok_len, var_line, E_NONE);
					scan_mode = M_IDLE;
					return 0;
				end
				if (b == 8'h0a) begin
					bump_line();
					scan_mode = M_PROBE_WS;
				end
				scan_pos++;
				return 1;
			end
			M_PROBE_MATCH: begin
				t = held_op;
				// 'b' is shared by byte and bool until the second letter
				if (!fin && t == 0 && held_cnt == 1) begin
					if (b == "y") t = 3;
					else if (b == "o") t = 4;
				end
				if (!fin && t >= 1 && t <= 4 && held_cnt < 4 && b == type_letter(t, held_cnt)) begin
					held_op        = t[7:0];
					held[held_cnt] = b;
					held_cnt++;
					scan_pos++;
					if (type_letter(t, held_cnt) == 8'h00) begin
						push_token(K_VAR, t[2:0], tok_start, tok_len, var_line, E_NONE);
						scan_mode = M_IDLE;
					end
					return 1;
				end
				push_token(K_VAR, T_UNKNOWN, tok_start, tok_len, var_line, E_NONE);
				scan_mode = M_IDLE;
				put_back(held_cnt);
				return 0;
			end
			default: begin
				scan_mode = M_IDLE;
				return 0;
			end
		endcase
	endfunction

	function automatic void predict_tokens(logic [7:0] b, logic fin);
		int guard;
		guard = 0;
		step_tokens.delete();
		rescan_q.delete();
		rescan_q.push_back(fin ? END_ITEM : int'(b));
		while (rescan_q.size() > 0 && guard < 64) begin
			guard++;
			if (scan_one(rescan_q[0])) void'(rescan_q.pop_front());
		end
		if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
		foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
	endfunction

	// sender: bursts of random length, random gaps between them
	task automatic send_byte(logic [7:0] b, logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		text_byte   <= b;
		end_of_text <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_tokens(b, fin);
		bytes_sent++;
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_byte(s[i], 1'b0);
	endtask

	task automatic close_text();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		texts_sent++;
	endtask

	// receiver: random out_ready, whose probability is redrawn as stall_phase advances
	int ready_pct = 100;
	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase % 64 == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pct <= 100;
				1: ready_pct <= 75;
				2: ready_pct <= 40;
				default: ready_pct <= 10;
			endcase
		end
		out_ready <= ($urandom_range(1, 100) <= ready_pct);
	end

	always @(posedge clk) begin
		token_t exp_tok;
		if (arst_n && out_valid && out_ready) begin
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				$error("token with nothing expected: kind %0d start %0d", token_kind, token_start);
				fail_count++;
			end else begin
				exp_tok = expected_tokens.pop_front();
				if (token_kind !== exp_tok.kind) begin
					$error("token_kind expected %0d got %0d", exp_tok.kind, token_kind);
					fail_count++;
				end
				if (value_type !== exp_tok.vtype) begin
					$error("value_type expected %0d got %0d", exp_tok.vtype, value_type);
					fail_count++;
				end
				if (token_start !== exp_tok.start) begin
					$error("token_start expected %0d got %0d", exp_tok.start, token_start);
					fail_count++;
				end
				if (token_length !== exp_tok.len) begin
					$error("token_length expected %0d got %0d", exp_tok.len, token_length);
					fail_count++;
				end
				if (line_number !== exp_tok.line) begin
					$error("line_number expected %0d got %0d", exp_tok.line, line_number);
					fail_count++;
				end
				if (error_code !== exp_tok.err) begin
					$error("error_code expected %0d got %0d", exp_tok.err, error_code);
					fail_count++;
				end
				if (last_of_run !== exp_tok.last) begin
					$error("last_of_run expected %0d got %0d", exp_tok.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	task automatic test_keywords_and_operators();
		send_text("var while if else true false fn return fnx _if iff\n");
		send_text("( ) ; + - * / , ! != = == < <= > >= 0 9 123\n");
		close_text();
	endtask

	task automatic test_char_literals();
		send_text("'a' 'Z' '1' 'ab '");
		close_text();
		send_text("'");
		close_text();
	endtask

	task automatic test_comments_and_odd_bytes();
		send_text("a // note\nb /x\r\t@");
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_text("//tail");
		close_text();
	endtask

	task automatic test_type_probe();
		send_text("var int var char var byte var bool var integer var bo var ch var i\n");
		send_text("var\n// c\n bool var /x var // open");
		close_text();
		send_text("var cx");
		close_text();
	endtask

	function automatic string random_piece();
		string words [10] = '{"var", "while", "if", "else", "true", "false", "fn", "return",
			"x1", "_tmp"};
		string types [7] = '{"int", "char", "byte", "bool", "in", "by", "bo"};
		string ops [17] = '{"(", ")", ";", "+", "-", "*", "/", ",", "!", "!=", "=", "==",
			"<", "<=", ">", ">=", "'"};
		string seps [6] = '{" ", "\n", "\t", "\r", "  ", ""};
		string s;
		case ($urandom_range(0, 7))
			0, 1: s = words[$urandom_range(0, 9)];
			2: s = $sformatf("%0d", $urandom_range(0, 99999));
			3: s = $sformatf("'%c%s", 8'($urandom_range(97, 122)),
				($urandom_range(0, 3) != 0) ? "'" : "");
			4: s = ops[$urandom_range(0, 16)];
			5: s = "// rest\n";
			default: s = {"var", seps[$urandom_range(0, 5)],
				($urandom_range(0, 4) == 0) ? "// c\n" : "", types[$urandom_range(0, 6)]};
		endcase
		return {s, seps[$urandom_range(0, 5)]};
	endfunction

	task automatic test_random_text(int count);
		int start_bytes;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < count) begin
			if ($urandom_range(0, 11) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
			else send_text(random_piece());
			if ($urandom_range(0, 40) == 0) close_text();
		end
		close_text();
	endtask

	initial begin
		int waited;
		scanner_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_keywords_and_operators();
		test_char_literals();
		test_comments_and_odd_bytes();
		test_type_probe();
		test_random_text(200);
		in_valid <= 1'b0;
		waited = 0;
		while (expected_tokens.size() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (30) @(posedge clk);
		if (expected_tokens.size() > 0) begin
			$error("%0d tokens never arrived", expected_tokens.size());
			fail_count++;
		end
		$display("covered %0d bytes in %0d texts, %0d tokens checked", bytes_sent, texts_sent,
			tokens_seen);
		$display("incl. keywords, operators, char literals, comments, type probes, random text");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#30ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
